### hdl/hrfe_pkg.sv
package hrfe_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int POS_W = 4;
  localparam int JOB_BYTES = 5;
  localparam int JOB_BITS_W = JOB_BYTES * BYTE_W;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NO_RECORD = 2'd1;
  localparam logic [1:0] ERR_BUSY = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CHAR_NULL = 7'h00;

  localparam logic [POS_W-1:0] POS_HDR_LAST = 4'd8;
  localparam logic [POS_W-1:0] POS_HDR_CKS_LAST = 4'd10;
  localparam logic [POS_W-1:0] POS_DATA_LAST = 4'd1;
  localparam logic [POS_W-1:0] POS_DATA_CKS_LAST = 4'd3;
  localparam logic [POS_W-1:0] POS_ERR_LAST = 4'd0;

  localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_HDR,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    logic [1:0] err;
    logic with_cks;
    logic [POS_W-1:0] last_pos;
    logic [JOB_BITS_W-1:0] bytes;
  } job_t;

endpackage

### hdl/hex_record_frame_encoder.sv
// hex record frame encoder
// input channel: in_valid/in_stall with opcode, record_address, record_type,
// data_count and data_byte; opcode 0 opens a record, opcode 1 carries a byte
// output channel: out_valid/out_stall, one ascii character per transaction
// with last_of_run, record_done and error_code alongside
// an open transaction gives ':' plus eight hex digits, and the two checksum
// digits as well when the count is zero; a data transaction gives two digits,
// plus the checksum digits on the last byte of the record
// a misplaced transaction gives one character with a non-zero error_code
// an accepted job is written to the job queue, then to the output register
// throughput: the character serialiser emits one character per cycle while
// out_stall is low, two per data transaction (four with checksum), nine or
// eleven per header; intake runs ahead by up to the job queue depth
// in_stall rises only when the job queue is full
// reset clears the record state, the queue, out_valid and the character position
// while out_stall is high the output character holds and the queue fills
module hex_record_frame_encoder #(
  parameter int FIFO_DEPTH = hrfe_pkg::FIFO_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input logic opcode,
  input logic [15:0] record_address,
  input logic [7:0] record_type,
  input logic [7:0] data_count,
  input logic [7:0] data_byte,
  output logic out_valid,
  input logic out_stall,
  output logic [6:0] out_char,
  output logic last_of_run,
  output logic record_done,
  output logic [1:0] error_code
);
  import hrfe_pkg::*;

  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  hrfe_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .record_address(record_address),
    .record_type(record_type),
    .data_count(data_count),
    .data_byte(data_byte),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(push_job)
  );

  hrfe_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(push_job),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .head_job(head_job)
  );

  hrfe_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_job(head_job),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .last_of_run(last_of_run),
    .record_done(record_done),
    .error_code(error_code)
  );

endmodule

### hdl/hrfe_front.sv
module hrfe_front (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input logic opcode,
  input logic [15:0] record_address,
  input logic [7:0] record_type,
  input logic [7:0] data_count,
  input logic [7:0] data_byte,
  input logic q_full,
  output logic q_push,
  output hrfe_pkg::job_t q_job
);
  import hrfe_pkg::*;

  logic record_open;
  logic [BYTE_W-1:0] bytes_left;
  logic [BYTE_W-1:0] running_sum;
  logic record_open_next;
  logic [BYTE_W-1:0] bytes_left_next;
  logic [BYTE_W-1:0] running_sum_next;
  logic [BYTE_W-1:0] hdr_sum;
  logic [BYTE_W-1:0] data_sum;
  logic [BYTE_W-1:0] left_dec;

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full;

  assign hdr_sum = data_count + record_address[15:8] + record_address[7:0] + record_type;
  assign data_sum = running_sum + data_byte;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    record_open_next = record_open;
    bytes_left_next = bytes_left;
    running_sum_next = running_sum;
    q_job = '0;
    q_job.kind = JOB_ERR;
    q_job.last_pos = POS_ERR_LAST;
    if (!opcode) begin
      if (record_open) begin
        q_job.err = ERR_BUSY;
      end else begin
        running_sum_next = hdr_sum;
        q_job.kind = JOB_HDR;
        q_job.err = ERR_NONE;
        q_job.with_cks = (data_count == 8'd0);
        q_job.last_pos = (data_count == 8'd0) ? POS_HDR_CKS_LAST : POS_HDR_LAST;
        q_job.bytes = {data_count, record_address[15:8], record_address[7:0],
                       record_type, 8'd0 - hdr_sum};
        if (data_count != 8'd0) begin
          record_open_next = 1'b1;
          bytes_left_next = data_count;
        end
      end
    end else begin
      if (!record_open) begin
        q_job.err = ERR_NO_RECORD;
      end else begin
        running_sum_next = data_sum;
        bytes_left_next = left_dec;
        q_job.kind = JOB_DATA;
        q_job.err = ERR_NONE;
        q_job.with_cks = (left_dec == 8'd0);
        q_job.last_pos = (left_dec == 8'd0) ? POS_DATA_CKS_LAST : POS_DATA_LAST;
        q_job.bytes = {data_byte, 8'd0 - data_sum, 24'd0};
        if (left_dec == 8'd0) begin
          record_open_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_open <= 1'b0;
      bytes_left <= '0;
      running_sum <= '0;
    end else if (q_push) begin
      record_open <= record_open_next;
      bytes_left <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

### hdl/hrfe_fifo.sv
module hrfe_fifo #(
  parameter int DEPTH = hrfe_pkg::FIFO_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic push,
  input hrfe_pkg::job_t push_job,
  output logic full,
  input logic pop,
  output logic empty,
  output hrfe_pkg::job_t head_job
);
  import hrfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/hrfe_back.sv
module hrfe_back (
  input logic clk,
  input logic rst,
  input logic q_empty,
  input hrfe_pkg::job_t q_job,
  output logic q_pop,
  output logic out_valid,
  input logic out_stall,
  output logic [6:0] out_char,
  output logic last_of_run,
  output logic record_done,
  output logic [1:0] error_code
);
  import hrfe_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] nib_idx;
  logic [5:0] top_bit;
  logic [3:0] nibble;
  logic advance;
  logic at_last;
  logic [CHAR_W-1:0] char_next;

  assign advance = !out_valid || !out_stall;
  assign at_last = (pos == q_job.last_pos);
  assign q_pop = advance && !q_empty && at_last;

  assign nib_idx = (q_job.kind == JOB_HDR) ? pos - 1'b1 : pos;
  assign top_bit = 6'(JOB_BITS_W - 1) - {nib_idx, 2'b00};
  assign nibble = q_job.bytes[top_bit -: 4];

  always_comb begin
    unique case (q_job.kind)
      JOB_ERR: char_next = CHAR_NULL;
      JOB_HDR: char_next = (pos == '0) ? CHAR_COLON : HEX_DIGITS[nibble];
      JOB_DATA: char_next = HEX_DIGITS[nibble];
      default: char_next = CHAR_NULL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= '0;
    end else if (advance) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        pos <= at_last ? '0 : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      out_char <= char_next;
      last_of_run <= at_last;
      record_done <= at_last && q_job.with_cks;
      error_code <= q_job.err;
    end
  end

endmodule

### hdl/hrfe_checker.sv
module hrfe_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [6:0] out_char,
  input logic last_of_run,
  input logic record_done,
  input logic [1:0] error_code
);
  import hrfe_pkg::*;

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_done |-> last_of_run)
    else $error("record_done without last_of_run");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |->
      last_of_run && !record_done && out_char == CHAR_NULL)
    else $error("error transaction has wrong shape");

  a_colon_opens: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == CHAR_COLON |-> error_code == ERR_NONE && !last_of_run)
    else $error("colon not followed by header digits");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
    else $error("stalled output changed");

endmodule

bind hex_record_frame_encoder hrfe_checker u_hrfe_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_char(out_char),
  .last_of_run(last_of_run),
  .record_done(record_done),
  .error_code(error_code)
);

### bench/hex_record_frame_encoder_tb.sv
module hex_record_frame_encoder_tb;
  import hrfe_pkg::*;

  localparam logic OP_OPEN = 1'b0;
  localparam logic OP_DATA = 1'b1;
  localparam int ITEM_TARGET = 170;
  localparam int HOLD_AT = 40;
  localparam int HOLD_LEN = 300;
  localparam logic [87:0] NO_TXT = 88'd0;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_ERR,
    ROW_HDR11
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic op;
    logic [15:0] addr;
    logic [7:0] rtype;
    logic [7:0] cnt;
    logic [7:0] dbyte;
    logic [1:0] err;
    logic [87:0] txt;
  } stim_row_t;

  typedef struct packed {
    logic [6:0] ch;
    logic last;
    logic done;
    logic [1:0] err;
  } char_res_t;

  // directed rows: predicted results, error results, and complete zero-count records
  localparam stim_row_t DIR_TAB [17] = '{
    '{ROW_ERR,   OP_DATA, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, ERR_NO_RECORD, NO_TXT},
    '{ROW_HDR11, OP_OPEN, 16'h0000, 8'h00, 8'h00, 8'hFF, ERR_NONE, ":0000000000"},
    '{ROW_HDR11, OP_OPEN, 16'hFFFF, 8'hFF, 8'h00, 8'h00, ERR_NONE, ":00FFFFFF03"},
    '{ROW_PRED,  OP_OPEN, 16'h1234, 8'h00, 8'h02, 8'h00, ERR_NONE, NO_TXT},
    '{ROW_ERR,   OP_OPEN, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, ERR_BUSY, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'h0000, 8'h00, 8'h00, 8'h00, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, ERR_NONE, NO_TXT},
    '{ROW_ERR,   OP_DATA, 16'h0000, 8'h00, 8'h00, 8'h5A, ERR_NO_RECORD, NO_TXT},
    '{ROW_PRED,  OP_OPEN, 16'hABCD, 8'h01, 8'h01, 8'h00, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'h5555, 8'hAA, 8'h55, 8'h80, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_OPEN, 16'h8000, 8'h04, 8'h03, 8'hFF, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'h0000, 8'h00, 8'h00, 8'h7F, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'h0000, 8'h00, 8'h00, 8'h01, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'h0000, 8'h00, 8'h00, 8'hFE, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_OPEN, 16'h0001, 8'hFF, 8'h01, 8'h00, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_DATA, 16'h0000, 8'h00, 8'h00, 8'hFF, ERR_NONE, NO_TXT},
    '{ROW_PRED,  OP_OPEN, 16'hFFFF, 8'h05, 8'h00, 8'h00, ERR_NONE, NO_TXT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [15:0] record_address = 16'd0;
  logic [7:0] record_type = 8'd0;
  logic [7:0] data_count = 8'd0;
  logic [7:0] data_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] out_char;
  logic last_of_run;
  logic record_done;
  logic [1:0] error_code;

  logic enc_open = 1'b0;
  logic [7:0] enc_left = 8'd0;
  logic [7:0] enc_sum = 8'd0;

  char_res_t step_chars[$];
  char_res_t pending_chars[$];
  char_res_t head_char;
  int fail_count = 0;
  int items_sent = 0;
  int hold_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  hex_record_frame_encoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .record_address(record_address),
    .record_type(record_type),
    .data_count(data_count),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .last_of_run(last_of_run),
    .record_done(record_done),
    .error_code(error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'h30 + 7'(nib) : 7'h37 + 7'(nib);
  endfunction

  function automatic void emit_char(input logic [6:0] ch, input logic done,
                                    input logic [1:0] err);
    char_res_t c;
    c.ch = ch;
    c.last = 1'b0;
    c.done = done;
    c.err = err;
    step_chars.push_back(c);
  endfunction

  function automatic void emit_hex(input logic [7:0] b, input logic done);
    emit_char(hex_char(b[7:4]), 1'b0, ERR_NONE);
    emit_char(hex_char(b[3:0]), done, ERR_NONE);
  endfunction

  // characters caused by one transaction, record state updated
  function automatic void encode_item(input stim_row_t row);
    step_chars.delete();
    if (row.op == OP_OPEN) begin
      if (enc_open) begin
        emit_char(CHAR_NULL, 1'b0, ERR_BUSY);
      end else begin
        enc_sum = row.cnt + row.addr[15:8] + row.addr[7:0] + row.rtype;
        emit_char(CHAR_COLON, 1'b0, ERR_NONE);
        emit_hex(row.cnt, 1'b0);
        emit_hex(row.addr[15:8], 1'b0);
        emit_hex(row.addr[7:0], 1'b0);
        emit_hex(row.rtype, 1'b0);
        if (row.cnt == 8'd0) begin
          emit_hex(8'h00 - enc_sum, 1'b1);
        end else begin
          enc_open = 1'b1;
          enc_left = row.cnt;
        end
      end
    end else begin
      if (!enc_open) begin
        emit_char(CHAR_NULL, 1'b0, ERR_NO_RECORD);
      end else begin
        enc_sum = enc_sum + row.dbyte;
        emit_hex(row.dbyte, 1'b0);
        enc_left = enc_left - 8'd1;
        if (enc_left == 8'd0) begin
          emit_hex(8'h00 - enc_sum, 1'b1);
          enc_open = 1'b0;
        end
      end
    end
    step_chars[step_chars.size()-1].last = 1'b1;
  endfunction

  task automatic send_item(input stim_row_t row);
    int gap;
    char_res_t c;
    if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= row.op;
    record_address <= row.addr;
    record_type <= row.rtype;
    data_count <= row.cnt;
    data_byte <= row.dbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_item(row);
    if (row.kind == ROW_ERR) begin
      step_chars.delete();
      c.ch = CHAR_NULL;
      c.last = 1'b1;
      c.done = 1'b0;
      c.err = row.err;
      step_chars.push_back(c);
    end else if (row.kind == ROW_HDR11) begin
      step_chars.delete();
      for (int i = 0; i < 11; i++) begin
        c.ch = row.txt[8*(10-i) +: 7];
        c.last = (i == 10);
        c.done = (i == 10);
        c.err = ERR_NONE;
        step_chars.push_back(c);
      end
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected transaction: out_char %h error_code %0d", out_char, error_code);
        fail_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_char !== head_char.ch) begin
          $error("out_char: expected %h, got %h", head_char.ch, out_char);
          fail_count++;
        end
        if (last_of_run !== head_char.last) begin
          $error("last_of_run: expected %b, got %b", head_char.last, last_of_run);
          fail_count++;
        end
        if (record_done !== head_char.done) begin
          $error("record_done: expected %b, got %b", head_char.done, record_done);
          fail_count++;
        end
        if (error_code !== head_char.err) begin
          $error("error_code: expected %0d, got %0d", head_char.err, error_code);
          fail_count++;
        end
      end
    end
  end

  initial begin : rx_proc
    int n;
    forever begin
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      n = rx_quiet ? 0 : $urandom_range(0, 14);
      // long hold-off so the job queue fills and the input stalls
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : main_proc
    stim_row_t row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (DIR_TAB[i]) send_item(DIR_TAB[i]);
    // mostly well-formed records, some misplaced transactions
    while (items_sent < ITEM_TARGET) begin
      row.kind = ROW_PRED;
      row.addr = 16'($urandom);
      row.rtype = 8'($urandom);
      row.cnt = 8'($urandom);
      row.dbyte = 8'($urandom);
      row.err = ERR_NONE;
      row.txt = NO_TXT;
      if (enc_open) begin
        row.op = ($urandom_range(0, 11) == 0) ? OP_OPEN : OP_DATA;
      end else begin
        row.op = ($urandom_range(0, 11) == 0) ? OP_DATA : OP_OPEN;
        if (row.op == OP_OPEN) begin
          row.cnt = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 6));
        end
      end
      if (items_sent == HOLD_AT) hold_cycles = HOLD_LEN;
      send_item(row);
    end
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[hex_record_frame_encoder] OK");
    end else begin
      $display("[hex_record_frame_encoder] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("[hex_record_frame_encoder] ERROR");
    $finish;
  end

endmodule

### filelist.f
hdl/hrfe_pkg.sv
hdl/hrfe_front.sv
hdl/hrfe_fifo.sv
hdl/hrfe_back.sv
hdl/hex_record_frame_encoder.sv
hdl/hrfe_checker.sv
bench/hex_record_frame_encoder_tb.sv
